// ===== rtl/core/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 shared package
// Types, round constants, initial hash values and the SHA-256 mixing functions.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam int WQ_DEPTH = 4;
   localparam int WQ_PTR_W = $clog2(WQ_DEPTH);
   localparam int WQ_CNT_W = $clog2(WQ_DEPTH + 1);

   // word position just before the length words of a block
   localparam logic [3:0] PRE_LEN_POS = 4'd13;

   localparam logic [7:0][31:0] IV_VALUES = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam logic [31:0] PAD_MARK = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] word;
      logic        blk_last;   // last word of the final block of a message
   } wq_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } wq_status_type;

   typedef enum logic [2:0] {
      FR_ACCEPT,
      FR_PAD,
      FR_ZERO,
      FR_LEN_HI,
      FR_LEN_LO
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ROUND,
      BK_UPDATE,
      BK_OUT
   } back_state_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
      rotr = (x >> n) | (x << (6'd32 - {1'b0, n}));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k;
      unique case (t)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      round_k = k;
   endfunction

endpackage

// ===== rtl/core/sha_front.sv =====
// ----------------------------------------------------------------------------
// SHA-256 front end
// Packs incoming bytes into 32-bit block words and appends the message padding.
// ----------------------------------------------------------------------------
module sha_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [31:0]           req_data_word,
   input  logic [2:0]            req_valid_bytes,
   input  logic                  req_last_item,
   input  sha_pkg::wq_status_type q_status,
   output logic                  q_push,
   output sha_pkg::wq_entry_type q_entry
);
   import sha_pkg::*;

   front_state_type state_ff, state_in;
   logic [23:0]     pend_ff, pend_in;
   logic [1:0]      pend_n_ff, pend_n_in;
   logic [60:0]     count_ff, count_in;
   logic [3:0]      wpos_ff, wpos_in;

   logic [2:0]  take_n;
   logic [31:0] data_masked;
   logic [55:0] merged;
   logic [2:0]  total;
   logic        accept;

   assign accept = req_push && !req_full;

   always_comb begin
      take_n = (req_valid_bytes > 3'd4) ? 3'd4 : req_valid_bytes;
      unique case (take_n)
         3'd0:    data_masked = 32'h0;
         3'd1:    data_masked = {req_data_word[31:24], 24'h0};
         3'd2:    data_masked = {req_data_word[31:16], 16'h0};
         3'd3:    data_masked = {req_data_word[31:8], 8'h0};
         default: data_masked = req_data_word;
      endcase
      merged = {pend_ff, 32'h0} | ({data_masked, 24'h0} >> {pend_n_ff, 3'b000});
      total  = {1'b0, pend_n_ff} + take_n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FR_ACCEPT;
         pend_ff   <= '0;
         pend_n_ff <= '0;
         count_ff  <= '0;
         wpos_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         pend_ff   <= pend_in;
         pend_n_ff <= pend_n_in;
         count_ff  <= count_in;
         wpos_ff   <= wpos_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pend_in   = pend_ff;
      pend_n_in = pend_n_ff;
      count_in  = count_ff;
      q_push    = 1'b0;
      q_entry   = '{word: 32'h0, blk_last: 1'b0};
      req_full  = (state_ff != FR_ACCEPT) || q_status.full;

      unique case (state_ff)
         FR_ACCEPT: begin
            if (accept) begin
               count_in = count_ff + {58'h0, take_n};
               if (total[2]) begin
                  q_push        = 1'b1;
                  q_entry.word  = merged[55:24];
                  pend_in       = merged[23:0];
               end else begin
                  pend_in       = merged[55:32];
               end
               pend_n_in = total[1:0];
               if (req_last_item) begin
                  state_in = FR_PAD;
               end
            end
         end
         FR_PAD: begin
            if (!q_status.full) begin
               q_push       = 1'b1;
               q_entry.word = {pend_ff, 8'h0} | (PAD_MARK >> {pend_n_ff, 3'b000});
               state_in     = (wpos_ff == PRE_LEN_POS) ? FR_LEN_HI : FR_ZERO;
            end
         end
         FR_ZERO: begin
            if (!q_status.full) begin
               q_push = 1'b1;
               if (wpos_ff == PRE_LEN_POS) begin
                  state_in = FR_LEN_HI;
               end
            end
         end
         FR_LEN_HI: begin
            if (!q_status.full) begin
               q_push       = 1'b1;
               q_entry.word = count_ff[60:29];
               state_in     = FR_LEN_LO;
            end
         end
         FR_LEN_LO: begin
            if (!q_status.full) begin
               q_push           = 1'b1;
               q_entry.word     = {count_ff[28:0], 3'b000};
               q_entry.blk_last = 1'b1;
               pend_in          = '0;
               pend_n_in        = '0;
               count_in         = '0;
               state_in         = FR_ACCEPT;
            end
         end
         default: state_in = FR_ACCEPT;
      endcase

      wpos_in = q_push ? wpos_ff + 4'd1 : wpos_ff;
   end

endmodule

// ===== rtl/core/sha_wordq.sv =====
// ----------------------------------------------------------------------------
// SHA-256 word queue
// Short queue of block words between the front end and the round engine.
// ----------------------------------------------------------------------------
module sha_wordq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sha_pkg::wq_entry_type  push_entry,
   input  logic                   pop,
   output sha_pkg::wq_entry_type  head_entry,
   output sha_pkg::wq_status_type status
);
   import sha_pkg::*;

   wq_entry_type        mem_ff [WQ_DEPTH];
   logic [WQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [WQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [WQ_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      status.full  = (cnt_ff == WQ_CNT_W'(WQ_DEPTH));
      status.empty = (cnt_ff == '0);
      head_entry   = mem_ff[rd_ptr_ff];
      wr_ptr_in    = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in       = cnt_ff + WQ_CNT_W'(push) - WQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/sha_back.sv =====
// ----------------------------------------------------------------------------
// SHA-256 round engine; keeps the chaining state and shows the digest
// Runs one compression round per cycle, stalling in rounds 0..15 on an empty queue.
// ----------------------------------------------------------------------------
module sha_back (
   input  logic                   clock,
   input  logic                   reset,
   input  sha_pkg::wq_entry_type  q_head,
   input  sha_pkg::wq_status_type q_status,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [31:0]            rsp_digest_word,
   output logic [2:0]             rsp_word_index,
   output logic                   rsp_last_word
);
   import sha_pkg::*;

   back_state_type state_ff, state_in;
   logic [5:0]     t_ff, t_in;
   logic [2:0]     idx_ff, idx_in;
   logic           blk_last_ff;
   logic [31:0]    chain_ff [8];
   logic [31:0]    wv_ff [8];
   logic [31:0]    w_ff [16];

   logic        in_load;
   logic        advance;
   logic        load_wv;
   logic        add_chain;
   logic        drop_chain;
   logic [31:0] w_cur;
   logic [31:0] t1;
   logic [31:0] t2;

   assign in_load = (t_ff[5:4] == 2'b00);

   always_comb begin
      w_cur = in_load ? q_head.word
                      : small_sigma1(w_ff[14]) + w_ff[9] + small_sigma0(w_ff[1]) + w_ff[0];
      t1 = wv_ff[7] + big_sigma1(wv_ff[4])
         + ((wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]))
         + round_k(t_ff) + w_cur;
      t2 = big_sigma0(wv_ff[0])
         + ((wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         t_ff     <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         t_ff     <= t_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      t_in       = t_ff;
      idx_in     = idx_ff;
      q_pop      = 1'b0;
      advance    = 1'b0;
      load_wv    = 1'b0;
      add_chain  = 1'b0;
      drop_chain = 1'b0;
      rsp_empty  = 1'b1;

      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               load_wv  = 1'b1;
               t_in     = '0;
               state_in = BK_ROUND;
            end
         end
         BK_ROUND: begin
            // rounds 0..15 wait on the queue for their message word
            if (!in_load || !q_status.empty) begin
               advance = 1'b1;
               q_pop   = in_load;
               t_in    = t_ff + 6'd1;
               if (t_ff == 6'd63) begin
                  state_in = BK_UPDATE;
               end
            end
         end
         BK_UPDATE: begin
            add_chain = 1'b1;
            idx_in    = '0;
            state_in  = blk_last_ff ? BK_OUT : BK_IDLE;
         end
         BK_OUT: begin
            rsp_empty = 1'b0;
            if (rsp_pop) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  drop_chain = 1'b1;
                  state_in   = BK_IDLE;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   assign rsp_digest_word = chain_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 8; j++) begin
            chain_ff[j] <= IV_VALUES[j];
         end
      end else if (drop_chain) begin
         for (int j = 0; j < 8; j++) begin
            chain_ff[j] <= IV_VALUES[j];
         end
      end else if (add_chain) begin
         for (int j = 0; j < 8; j++) begin
            chain_ff[j] <= chain_ff[j] + wv_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_wv) begin
         for (int j = 0; j < 8; j++) begin
            wv_ff[j] <= chain_ff[j];
         end
      end else if (advance) begin
         wv_ff[0] <= t1 + t2;
         wv_ff[1] <= wv_ff[0];
         wv_ff[2] <= wv_ff[1];
         wv_ff[3] <= wv_ff[2];
         wv_ff[4] <= wv_ff[3] + t1;
         wv_ff[5] <= wv_ff[4];
         wv_ff[6] <= wv_ff[5];
         wv_ff[7] <= wv_ff[6];
      end
   end

   // schedule window: w_ff[15] holds the newest word
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < 15; j++) begin
            w_ff[j] <= w_ff[j + 1];
         end
         w_ff[15] <= w_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_last_ff <= 1'b0;
      end else if (q_pop && (t_ff == 6'd15)) begin
         blk_last_ff <= q_head.blk_last;
      end
   end

endmodule

// ===== rtl/core/sha256_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher: SHA-256 digest of a byte stream, up to four bytes a word
// Front takes one word a cycle into a 4-entry queue unless full or padding.
// Engine per 64-byte block: load, 64 rounds (one a cycle when fed), chain add.
// Digest: 1-2 blocks of padding after the last word, then 8 words, one a pop.
// Synchronous reset clears control and loads the SHA-256 initial hash values.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   // input word channel
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_last_item,
   // digest channel
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha_pkg::*;

   // Block words flow front -> queue -> round engine. The front end stalls
   // only on a full queue or while it writes padding; the round engine
   // stalls on an empty queue or while the digest is being drained.
   logic          q_push;
   logic          q_pop;
   wq_entry_type  q_push_entry;
   wq_entry_type  q_head;
   wq_status_type q_status;

   // Pack bytes into big-endian block words, append the 0x80 mark, the zero
   // fill and the 64-bit bit length on the last word of a message.
   sha_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data_word   (req_data_word),
      .req_valid_bytes (req_valid_bytes),
      .req_last_item   (req_last_item),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_entry         (q_push_entry)
   );

   // Decouple the byte packer from the round engine.
   sha_wordq u_wordq (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head_entry (q_head),
      .status     (q_status)
   );

   // Compress each block and hold the digest on the result ports until all
   // eight words are popped, then restore the initial hash values.
   sha_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_head          (q_head),
      .q_status        (q_status),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

`ifndef SYNTHESIS
   // never write into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full))
      else $error("word queue overflow");

   // never read from an empty queue
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_status.empty))
      else $error("word queue underflow");

   // digest words advance in order while draining
   a_digest_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_last_word) |=>
      (!rsp_empty && (rsp_word_index == $past(rsp_word_index) + 3'd1)))
      else $error("digest word order broken");

   // digest channel closes after the final word
   a_digest_close: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && rsp_last_word) |=> rsp_empty)
      else $error("digest shown past its last word");
`endif

endmodule
